### hdl/i2p_pkg.sv
package i2p_pkg;

  typedef logic [2:0] code_t;

  localparam code_t CODE_OPEN  = 3'd0;
  localparam code_t CODE_PLUS  = 3'd1;
  localparam code_t CODE_MINUS = 3'd2;
  localparam code_t CODE_TIMES = 3'd3;
  localparam code_t CODE_DIV   = 3'd4;

  localparam logic [7:0] CHAR_OPEN  = 8'h28;
  localparam logic [7:0] CHAR_CLOSE = 8'h29;
  localparam logic [7:0] CHAR_TIMES = 8'h2A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DIV   = 8'h2F;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNMATCHED = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

  function automatic logic [7:0] code_char(input code_t code);
    logic [7:0] ch;
    case (code)
      CODE_OPEN:  ch = CHAR_OPEN;
      CODE_PLUS:  ch = CHAR_PLUS;
      CODE_MINUS: ch = CHAR_MINUS;
      CODE_TIMES: ch = CHAR_TIMES;
      CODE_DIV:   ch = CHAR_DIV;
      default:    ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] code_prio(input code_t code);
    logic [1:0] prio;
    case (code)
      CODE_OPEN:  prio = 2'd3;
      CODE_PLUS:  prio = 2'd1;
      CODE_MINUS: prio = 2'd1;
      CODE_TIMES: prio = 2'd2;
      CODE_DIV:   prio = 2'd2;
      default:    prio = 2'd0;
    endcase
    return prio;
  endfunction

endpackage

### hdl/i2p_cell.sv
module i2p_cell (
  input  logic               clk,
  input  i2p_pkg::cell_ctl_t ctl,
  input  i2p_pkg::code_t     up_code,
  input  i2p_pkg::code_t     down_code,
  output i2p_pkg::code_t     code
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      code <= up_code;
    end else if (ctl.pop) begin
      code <= down_code;
    end
  end

endmodule

### hdl/infix_to_postfix_converter.sv
// Shunting-yard converter from infix to postfix characters.
// The input channel (valid, stall, symbol, end_of_expression) takes one ASCII
// character per item. The result channel (result_valid, result_stall, out_symbol,
// out_valid, last, status) sends one postfix character per item, and the last
// result of each input item carries last set. An input item that ends an
// expression or raises an error but sends no character gives one empty result
// with out_valid low. Every result of one input item carries the same status.
// The operator stack is a row of cells that shift down on a push and up on a pop,
// one pop per cycle while the output register is free. An input item goes through
// ST_OPER, ST_FLUSH and ST_DONE in turn; ST_OPER and ST_FLUSH pop the operators.
// One item is worked on at a time; stall stays high until its last result has
// entered the output register. The output register takes a new result in the
// cycle its current result is accepted; while result_stall holds a waiting
// result, the block holds until the register frees. Reset empties the stack and
// drops any result in flight.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       valid,
  output logic       stall,
  input  logic [7:0] symbol,
  input  logic       end_of_expression,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_symbol,
  output logic       out_valid,
  output logic       last,
  output logic [1:0] status
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_OPER  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [2:0] K_SPACE = 3'd0;
  localparam logic [2:0] K_OPEN  = 3'd1;
  localparam logic [2:0] K_CLOSE = 3'd2;
  localparam logic [2:0] K_OPER  = 3'd3;
  localparam logic [2:0] K_OTHER = 3'd4;

  logic [1:0]     state, state_next;
  logic [7:0]     sym_q;
  logic           end_q;
  logic [2:0]     kind_q;
  i2p_pkg::code_t code_q;
  logic [1:0]     status_q;
  logic [CW-1:0]  stack_count;
  logic [CW-1:0]  open_count;
  logic           hold_full;
  logic [7:0]     hold_symbol;

  logic [2:0]         kind_d;
  i2p_pkg::code_t     code_d;
  logic [1:0]         status_d;
  i2p_pkg::code_t     top_code;
  i2p_pkg::code_t     cell_code [STACK_DEPTH];
  i2p_pkg::cell_ctl_t ctl;
  logic               full;
  logic               pop_ok;
  logic               out_free;
  logic               accept;
  logic               emit;
  logic [7:0]         emit_symbol;
  logic               out_load;
  logic [7:0]         out_symbol_d;
  logic               out_valid_d;
  logic               last_d;

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      i2p_pkg::code_t up_code;
      i2p_pkg::code_t down_code;
      if (gi == 0) begin : g_top
        assign up_code = code_q;
      end else begin : g_mid
        assign up_code = cell_code[gi-1];
      end
      if (gi == STACK_DEPTH - 1) begin : g_bottom
        assign down_code = i2p_pkg::CODE_OPEN;
      end else begin : g_inner
        assign down_code = cell_code[gi+1];
      end
      i2p_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .up_code   (up_code),
        .down_code (down_code),
        .code      (cell_code[gi])
      );
    end
  endgenerate

  assign top_code = cell_code[0];
  assign full     = stack_count == CW'(STACK_DEPTH);
  assign out_free = !result_valid || !result_stall;
  assign stall    = rst || (state != ST_IDLE);
  assign accept   = valid && !stall;

  always_comb begin
    kind_d = K_OTHER;
    code_d = i2p_pkg::CODE_OPEN;
    case (symbol)
      i2p_pkg::CHAR_SPACE: kind_d = K_SPACE;
      i2p_pkg::CHAR_OPEN:  kind_d = K_OPEN;
      i2p_pkg::CHAR_CLOSE: kind_d = K_CLOSE;
      i2p_pkg::CHAR_PLUS: begin
        kind_d = K_OPER;
        code_d = i2p_pkg::CODE_PLUS;
      end
      i2p_pkg::CHAR_MINUS: begin
        kind_d = K_OPER;
        code_d = i2p_pkg::CODE_MINUS;
      end
      i2p_pkg::CHAR_TIMES: begin
        kind_d = K_OPER;
        code_d = i2p_pkg::CODE_TIMES;
      end
      i2p_pkg::CHAR_DIV: begin
        kind_d = K_OPER;
        code_d = i2p_pkg::CODE_DIV;
      end
      default: kind_d = K_OTHER;
    endcase
  end

  // An operator overflows only if it pops nothing, so the status of an item is
  // known when it is accepted.
  always_comb begin
    status_d = i2p_pkg::STATUS_OK;
    case (kind_d)
      K_OPEN: begin
        if (full) begin
          status_d = i2p_pkg::STATUS_OVERFLOW;
        end
      end
      K_CLOSE: begin
        if (open_count == '0) begin
          status_d = i2p_pkg::STATUS_UNMATCHED;
        end
      end
      K_OPER: begin
        if (full && (top_code == i2p_pkg::CODE_OPEN ||
                     i2p_pkg::code_prio(code_d) > i2p_pkg::code_prio(top_code))) begin
          status_d = i2p_pkg::STATUS_OVERFLOW;
        end
      end
      default: status_d = i2p_pkg::STATUS_OK;
    endcase
  end

  assign pop_ok = (stack_count != '0) && (top_code != i2p_pkg::CODE_OPEN) &&
                  (i2p_pkg::code_prio(code_q) <= i2p_pkg::code_prio(top_code));

  always_comb begin
    state_next   = state;
    ctl.push     = 1'b0;
    ctl.pop      = 1'b0;
    emit         = 1'b0;
    emit_symbol  = i2p_pkg::code_char(top_code);
    out_load     = 1'b0;
    out_symbol_d = hold_symbol;
    out_valid_d  = 1'b1;
    last_d       = 1'b0;
    if (state == ST_IDLE) begin
      if (accept) begin
        state_next = ST_OPER;
      end
    end else if (out_free) begin
      case (state)
        ST_OPER: begin
          case (kind_q)
            K_CLOSE: begin
              if (status_q == i2p_pkg::STATUS_OK) begin
                ctl.pop = 1'b1;
                if (top_code == i2p_pkg::CODE_OPEN) begin
                  state_next = ST_FLUSH;
                end else begin
                  emit = 1'b1;
                end
              end else begin
                state_next = ST_FLUSH;
              end
            end
            K_OPER: begin
              if (pop_ok) begin
                ctl.pop = 1'b1;
                emit    = 1'b1;
              end else begin
                ctl.push   = !full;
                state_next = ST_FLUSH;
              end
            end
            K_OPEN: begin
              ctl.push   = !full;
              state_next = ST_FLUSH;
            end
            K_OTHER: begin
              emit        = 1'b1;
              emit_symbol = sym_q;
              state_next  = ST_FLUSH;
            end
            default: state_next = ST_FLUSH;
          endcase
        end
        ST_FLUSH: begin
          if (end_q && stack_count != '0) begin
            ctl.pop = 1'b1;
            emit    = 1'b1;
          end else begin
            state_next = ST_DONE;
          end
        end
        ST_DONE: begin
          last_d     = 1'b1;
          state_next = ST_IDLE;
          if (hold_full) begin
            out_load = 1'b1;
          end else if (end_q || status_q != i2p_pkg::STATUS_OK) begin
            out_load     = 1'b1;
            out_symbol_d = 8'h00;
            out_valid_d  = 1'b0;
          end
        end
        default: state_next = ST_IDLE;
      endcase
      // A new character pushes the held one out; the held one becomes the
      // last result only when the item finishes.
      if (emit && hold_full) begin
        out_load = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      stack_count  <= '0;
      open_count   <= '0;
      hold_full    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.push) begin
        stack_count <= stack_count + CW'(1);
        if (code_q == i2p_pkg::CODE_OPEN) begin
          open_count <= open_count + CW'(1);
        end
      end else if (ctl.pop) begin
        stack_count <= stack_count - CW'(1);
        if (top_code == i2p_pkg::CODE_OPEN) begin
          open_count <= open_count - CW'(1);
        end
      end
      if (emit) begin
        hold_full <= 1'b1;
      end else if (state == ST_DONE && out_free) begin
        hold_full <= 1'b0;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sym_q    <= symbol;
      end_q    <= end_of_expression;
      kind_q   <= kind_d;
      code_q   <= (kind_d == K_OPER) ? code_d : i2p_pkg::CODE_OPEN;
      status_q <= status_d;
    end
    if (emit) begin
      hold_symbol <= emit_symbol;
    end
    if (out_load) begin
      out_symbol <= out_symbol_d;
      out_valid  <= out_valid_d;
      last       <= last_d;
      status     <= status_q;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= CW'(STACK_DEPTH))
    else $error("stack count exceeds depth");

  a_open_bound: assert property (@(posedge clk) disable iff (rst)
    open_count <= stack_count)
    else $error("open parenthesis count exceeds stack count");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !hold_full)
    else $error("character left in hold while idle");

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    result_valid && !out_valid |-> out_symbol == 8'h00 && last)
    else $error("empty result is malformed");

  a_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(ctl.push && ctl.pop))
    else $error("push and pop in the same cycle");

endmodule

### verif/infix_to_postfix_converter_test.sv
module infix_to_postfix_converter_test;

  localparam int STACK_DEPTH = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS_PER_PHASE = 30;

  typedef struct {
    logic [7:0] sym;
    logic       sym_valid;
    logic       final_one;
    logic [1:0] st;
  } postfix_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       valid = 1'b0;
  logic       stall;
  logic [7:0] symbol = 8'h00;
  logic       end_of_expression = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] out_symbol;
  logic       out_valid;
  logic       last;
  logic [1:0] status;

  i2p_pkg::code_t op_stack [STACK_DEPTH];
  int             op_depth = 0;
  postfix_char_t  postfix_q [$];

  int error_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;
  int hold_left = 0;

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .valid(valid),
    .stall(stall),
    .symbol(symbol),
    .end_of_expression(end_of_expression),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_symbol(out_symbol),
    .out_valid(out_valid),
    .last(last),
    .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The receiver either follows the random stall rate or holds off for a long stretch.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    postfix_char_t want;
    if (!rst && result_valid && !result_stall) begin
      if (postfix_q.size() == 0) begin
        $error("unexpected result: out_symbol %h out_valid %b", out_symbol, out_valid);
        error_count++;
      end else begin
        want = postfix_q.pop_front();
        if (out_symbol !== want.sym) begin
          $error("out_symbol: expected %h, actual %h", want.sym, out_symbol);
          error_count++;
        end
        if (out_valid !== want.sym_valid) begin
          $error("out_valid: expected %b, actual %b", want.sym_valid, out_valid);
          error_count++;
        end
        if (last !== want.final_one) begin
          $error("last: expected %b, actual %b", want.final_one, last);
          error_count++;
        end
        if (status !== want.st) begin
          $error("status: expected %0d, actual %0d", want.st, status);
          error_count++;
        end
      end
    end
  end

  function automatic logic [7:0] symbol_for_code(input i2p_pkg::code_t code);
    case (code)
      i2p_pkg::CODE_OPEN:  return i2p_pkg::CHAR_OPEN;
      i2p_pkg::CODE_PLUS:  return i2p_pkg::CHAR_PLUS;
      i2p_pkg::CODE_MINUS: return i2p_pkg::CHAR_MINUS;
      i2p_pkg::CODE_TIMES: return i2p_pkg::CHAR_TIMES;
      default:             return i2p_pkg::CHAR_DIV;
    endcase
  endfunction

  function automatic int rank_of(input i2p_pkg::code_t code);
    case (code)
      i2p_pkg::CODE_OPEN:                     return 3;
      i2p_pkg::CODE_TIMES, i2p_pkg::CODE_DIV: return 2;
      default:                                return 1;
    endcase
  endfunction

  function automatic void predict_postfix(input logic [7:0] sym, input logic eoe);
    logic [7:0]     chars [$];
    logic [1:0]     st;
    i2p_pkg::code_t code;
    bit             found;
    postfix_char_t  item;
    st = i2p_pkg::STATUS_OK;
    found = 1'b0;
    case (sym)
      i2p_pkg::CHAR_SPACE: begin
      end
      i2p_pkg::CHAR_OPEN: begin
        if (op_depth == STACK_DEPTH) begin
          st = i2p_pkg::STATUS_OVERFLOW;
        end else begin
          op_stack[op_depth] = i2p_pkg::CODE_OPEN;
          op_depth++;
        end
      end
      i2p_pkg::CHAR_CLOSE: begin
        for (int i = 0; i < op_depth; i++) begin
          if (op_stack[i] == i2p_pkg::CODE_OPEN) found = 1'b1;
        end
        if (!found) begin
          st = i2p_pkg::STATUS_UNMATCHED;
        end else begin
          while (op_depth > 0) begin
            op_depth--;
            if (op_stack[op_depth] == i2p_pkg::CODE_OPEN) break;
            chars.push_back(symbol_for_code(op_stack[op_depth]));
          end
        end
      end
      i2p_pkg::CHAR_PLUS, i2p_pkg::CHAR_MINUS, i2p_pkg::CHAR_TIMES,
      i2p_pkg::CHAR_DIV: begin
        case (sym)
          i2p_pkg::CHAR_PLUS:  code = i2p_pkg::CODE_PLUS;
          i2p_pkg::CHAR_MINUS: code = i2p_pkg::CODE_MINUS;
          i2p_pkg::CHAR_TIMES: code = i2p_pkg::CODE_TIMES;
          default:             code = i2p_pkg::CODE_DIV;
        endcase
        while (op_depth > 0 && op_stack[op_depth - 1] != i2p_pkg::CODE_OPEN &&
               rank_of(code) <= rank_of(op_stack[op_depth - 1])) begin
          op_depth--;
          chars.push_back(symbol_for_code(op_stack[op_depth]));
        end
        if (op_depth == STACK_DEPTH) begin
          st = i2p_pkg::STATUS_OVERFLOW;
        end else begin
          op_stack[op_depth] = code;
          op_depth++;
        end
      end
      default: begin
        chars.push_back(sym);
      end
    endcase
    if (eoe) begin
      while (op_depth > 0) begin
        op_depth--;
        chars.push_back(symbol_for_code(op_stack[op_depth]));
      end
    end
    if (chars.size() == 0 && (eoe || st != i2p_pkg::STATUS_OK)) begin
      item.sym = 8'h00;
      item.sym_valid = 1'b0;
      item.final_one = 1'b1;
      item.st = st;
      postfix_q.push_back(item);
    end
    for (int i = 0; i < chars.size(); i++) begin
      item.sym = chars[i];
      item.sym_valid = 1'b1;
      item.final_one = (i == chars.size() - 1);
      item.st = st;
      postfix_q.push_back(item);
    end
  endfunction

  task automatic send_symbol(input logic [7:0] sym, input logic eoe);
    while ($urandom_range(99) < idle_pct) begin
      valid <= 1'b0;
      @(posedge clk);
    end
    valid <= 1'b1;
    symbol <= sym;
    end_of_expression <= eoe;
    @(posedge clk);
    while (stall) @(posedge clk);
    predict_postfix(sym, eoe);
    if (sym != i2p_pkg::CHAR_SPACE) items_sent++;
  endtask

  task automatic send_string(input string text);
    for (int i = 0; i < text.len(); i++) begin
      send_symbol(text[i], i == text.len() - 1);
    end
  endtask

  task automatic wait_for_postfix_drain();
    valid <= 1'b0;
    while (postfix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    idle_pct = sender_pct;
    stall_pct = receiver_pct;
  endtask

  function automatic logic [7:0] pick_operand();
    logic [7:0] ch;
    if ($urandom_range(3) == 0) begin
      do begin
        ch = 8'($urandom_range(255));
      end while (ch inside {i2p_pkg::CHAR_SPACE, i2p_pkg::CHAR_OPEN, i2p_pkg::CHAR_CLOSE,
                            i2p_pkg::CHAR_PLUS, i2p_pkg::CHAR_MINUS,
                            i2p_pkg::CHAR_TIMES, i2p_pkg::CHAR_DIV});
    end else begin
      ch = 8'(8'h61 + $urandom_range(25));
    end
    return ch;
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(3))
      0:       return i2p_pkg::CHAR_PLUS;
      1:       return i2p_pkg::CHAR_MINUS;
      2:       return i2p_pkg::CHAR_TIMES;
      default: return i2p_pkg::CHAR_DIV;
    endcase
  endfunction

  task automatic send_expression(input bit broken, input int open_first);
    logic [7:0] chars [$];
    int         terms;
    int         depth;
    bit         close_it;
    terms = 1 + $urandom_range(6);
    depth = 0;
    for (int i = 0; i < open_first; i++) begin
      chars.push_back(i2p_pkg::CHAR_OPEN);
      depth++;
    end
    for (int i = 0; i < terms; i++) begin
      while (depth < 20 && $urandom_range(3) == 0) begin
        chars.push_back(i2p_pkg::CHAR_OPEN);
        depth++;
      end
      if ($urandom_range(4) == 0) chars.push_back(i2p_pkg::CHAR_SPACE);
      chars.push_back(pick_operand());
      while (depth > 0 && $urandom_range(2) == 0) begin
        chars.push_back(i2p_pkg::CHAR_CLOSE);
        depth--;
      end
      if (i < terms - 1) chars.push_back(pick_operator());
    end
    if (!broken) begin
      while (depth > 0) begin
        chars.push_back(i2p_pkg::CHAR_CLOSE);
        depth--;
      end
    end else begin
      case ($urandom_range(3))
        0: chars.push_back(i2p_pkg::CHAR_CLOSE);
        1: chars.delete($urandom_range(chars.size() - 1));
        2: chars.insert($urandom_range(chars.size() - 1), pick_operator());
        default: chars.push_front(i2p_pkg::CHAR_CLOSE);
      endcase
    end
    close_it = !broken || ($urandom_range(1) == 1);
    for (int i = 0; i < chars.size(); i++) begin
      send_symbol(chars[i], close_it && (i == chars.size() - 1));
    end
  endtask

  task automatic test_operand_extremes();
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b1);
    send_symbol(i2p_pkg::CHAR_SPACE, 1'b1);
    wait_for_postfix_drain();
  endtask

  task automatic test_operator_priority();
    send_string("a-b*c/d+e");
    wait_for_postfix_drain();
  endtask

  task automatic test_parentheses();
    send_string("(a+b)* c");
    send_string("((");
    send_symbol(i2p_pkg::CHAR_CLOSE, 1'b0);
    wait_for_postfix_drain();
  endtask

  task automatic test_stack_full();
    for (int i = 0; i < STACK_DEPTH; i++) begin
      send_symbol(i2p_pkg::CHAR_OPEN, 1'b0);
    end
    send_symbol(i2p_pkg::CHAR_OPEN, 1'b0);
    send_symbol(i2p_pkg::CHAR_TIMES, 1'b0);
    send_symbol(8'h71, 1'b1);
    wait_for_postfix_drain();
  endtask

  task automatic test_random_expressions();
    int goal;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       set_idling(0, 0);
        1:       set_idling(83, 0);
        2:       set_idling(0, 83);
        default: set_idling(33, 33);
      endcase
      goal = items_sent + RANDOM_ITEMS_PER_PHASE;
      while (items_sent < goal) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5, 6: send_expression(1'b0, 0);
          7:                   send_expression(1'b1, 0);
          8:                   send_expression(1'b0, 10 + $urandom_range(8));
          default: send_symbol(8'($urandom_range(255)), $urandom_range(3) == 0);
        endcase
      end
      wait_for_postfix_drain();
    end
  endtask

  task automatic test_receiver_holdoff();
    set_idling(0, 0);
    hold_req = !hold_req;
    send_expression(1'b0, 0);
    send_expression(1'b0, 0);
    send_expression(1'b0, 0);
    wait_for_postfix_drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_operand_extremes();
    test_operator_priority();
    test_parentheses();
    test_stack_full();
    test_random_expressions();
    test_receiver_holdoff();
    wait_for_postfix_drain();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hdl/i2p_pkg.sv
hdl/i2p_cell.sv
hdl/infix_to_postfix_converter.sv
verif/infix_to_postfix_converter_test.sv
